// File: rtl/core/lei_pkg.sv
// lei_pkg: shared types, sequencer step codes and operand helpers for the
// lorenz euler integrator. no dependencies.
package lei_pkg;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // configuration register indexes
  localparam logic [1:0] REG_SIGMA = 2'd0;
  localparam logic [1:0] REG_RHO   = 2'd1;
  localparam logic [1:0] REG_BETA  = 2'd2;

  // input action codes
  localparam logic ACT_STEP = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam int CoordW = 32;
  localparam int DtW    = 16;
  localparam int DerivW = 48;
  localparam int MulAW  = 18;
  localparam int MulBW  = 32;
  localparam int ProdW  = MulAW + MulBW;
  localparam int AccW   = 66;

  typedef logic [3:0] step_t;

  // sequencer steps at which a finished accumulator value is consumed
  localparam step_t STEP_FIN_DX = 4'd3;
  localparam step_t STEP_FIN_DY = 4'd5;
  localparam step_t STEP_FIN_XY = 4'd7;
  localparam step_t STEP_FIN_DZ = 4'd9;
  localparam step_t STEP_FIN_PX = 4'd11;
  localparam step_t STEP_FIN_PY = 4'd13;
  localparam step_t STEP_FIN_PZ = 4'd15;
  localparam step_t STEP_LAST   = 4'd15;

  // upper signed part of a 33-bit operand, floor(a / 2^16)
  function automatic logic signed [MulAW-1:0] op_hi(input logic [32:0] a);
    op_hi = {a[32], a[32:16]};
  endfunction

  // lower unsigned 16 bits of a 33-bit operand
  function automatic logic signed [MulAW-1:0] op_lo(input logic [32:0] a);
    op_lo = {2'b00, a[15:0]};
  endfunction

endpackage

// File: rtl/core/lorenz_euler_integrator.sv
// lorenz_euler_integrator: one fixed point forward euler step of the lorenz
// system per request, on a single shared 18x32 multiplier and accumulator.
// depends on lei_pkg.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------
//  in_     | in  | in_tvalid/tready    | tuser: action; tdata: dt, x, y, z loads
//  out_    | out | out_tvalid/tready   | tdata: x, y, z; tuser: overflow
//  cfg_    | in  | cfg_valid/ready     | cfg_index, cfg_data (sigma, rho, beta)
//
// a step request runs the sequencer through its steps, feeding 14 partial
// products through the one multiplier, then moves the point into the output
// register and returns to idle to accept the next request. a load request goes
// straight to the output stage. in_tready is high only while idle; a result
// waiting in the output register blocks only the final transfer.
// rst_n is synchronous: point goes to 0.1, gains to their defaults.
// cfg_ready is always high; writes to index 3 are dropped.
module lorenz_euler_integrator
  import lei_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [0:0]   in_tuser,   // [0] action
  input  logic [111:0] in_tdata,   // [15:0] time_step, [47:16] load_x,
                                   // [79:48] load_y, [111:80] load_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // [31:0] out_x, [63:32] out_y, [95:64] out_z
  output logic [0:0]   out_tuser,  // [0] overflow
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // reset values, scaled to the fraction width
  localparam logic [63:0] SigmaRst = 64'd10 << FRAC_BITS;
  localparam logic [63:0] RhoRst   = 64'd28 << FRAC_BITS;
  localparam logic [63:0] BetaRst  = ((64'd8 << FRAC_BITS) + 64'd1) / 64'd3;
  localparam logic [63:0] PointRst = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam int TmpW = AccW - FRAC_BITS;

  state_t state_r, state_nxt;
  step_t  step_r;

  logic signed [CoordW-1:0] sigma_r, rho_r, beta_r;
  logic signed [CoordW-1:0] x_r, y_r, z_r;
  logic [DtW-1:0]           dt_r;
  logic signed [DerivW-1:0] dx_r, dy_r, dz_r;
  logic signed [TmpW-1:0]   tmp_r;
  logic                     ovf_r;

  // shared multiplier and accumulator
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic                    mul_en, mul_hi, mul_clr;
  logic signed [ProdW-1:0] prod_nxt, prod_r;
  logic                    prod_en_r, prod_hi_r, prod_clr_r;
  logic signed [AccW-1:0]  prod_ext, acc_nxt, acc_r;

  logic [32:0] d_yx, d_rz, x33, beta33;
  logic [DtW+1:0] dt_op;

  logic signed [AccW-1:0]   mf, deriv_v;
  logic                     deriv_ovf;
  logic signed [DerivW-1:0] deriv_sat;
  logic signed [CoordW-1:0] coord_old;
  logic signed [AccW-1:0]   coord_v;
  logic                     coord_ovf;
  logic signed [CoordW-1:0] coord_sat;

  logic in_acc, emit_go;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign emit_go   = (state_r == S_EMIT) && (!out_tvalid || out_tready);

  // operand forms for the products of a step
  assign d_yx   = {y_r[31], y_r} - {x_r[31], x_r};
  assign d_rz   = {rho_r[31], rho_r} - {z_r[31], z_r};
  assign x33    = {x_r[31], x_r};
  assign beta33 = {beta_r[31], beta_r};
  assign dt_op  = {2'b00, dt_r};

  // micro-program: two partial products per fixed point product,
  // high part shifted by 16 on accumulation, first one clears the accumulator
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_en  = 1'b0;
    mul_hi  = 1'b0;
    mul_clr = 1'b0;
    if (state_r == S_RUN) begin
      unique case (step_r)
        4'd0: begin mul_a = op_hi(d_yx);   mul_b = sigma_r; mul_hi = 1'b1; mul_clr = 1'b1; end
        4'd1: begin mul_a = op_lo(d_yx);   mul_b = sigma_r; end
        4'd2: begin mul_a = op_hi(d_rz);   mul_b = x_r;     mul_hi = 1'b1; mul_clr = 1'b1; end
        4'd3: begin mul_a = op_lo(d_rz);   mul_b = x_r;     end
        4'd4: begin mul_a = op_hi(x33);    mul_b = y_r;     mul_hi = 1'b1; mul_clr = 1'b1; end
        4'd5: begin mul_a = op_lo(x33);    mul_b = y_r;     end
        4'd6: begin mul_a = op_hi(beta33); mul_b = z_r;     mul_hi = 1'b1; mul_clr = 1'b1; end
        4'd7: begin mul_a = op_lo(beta33); mul_b = z_r;     end
        4'd8: begin
          mul_a = dt_op; mul_b = dx_r[47:16]; mul_hi = 1'b1; mul_clr = 1'b1;
        end
        4'd9:  begin mul_a = dt_op; mul_b = {16'b0, dx_r[15:0]}; end
        4'd10: begin
          mul_a = dt_op; mul_b = dy_r[47:16]; mul_hi = 1'b1; mul_clr = 1'b1;
        end
        4'd11: begin mul_a = dt_op; mul_b = {16'b0, dy_r[15:0]}; end
        4'd12: begin
          mul_a = dt_op; mul_b = dz_r[47:16]; mul_hi = 1'b1; mul_clr = 1'b1;
        end
        4'd13: begin mul_a = dt_op; mul_b = {16'b0, dz_r[15:0]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
      mul_en = (step_r <= 4'd13);
    end
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_ext = {{(AccW-ProdW){prod_r[ProdW-1]}}, prod_r};
  assign acc_nxt  = (prod_clr_r ? '0 : acc_r) + (prod_hi_r ? (prod_ext <<< 16) : prod_ext);

  // derivative finish: floor shift, combine, clamp to 48 bits
  assign mf = acc_r >>> FRAC_BITS;
  always_comb begin
    priority case (step_r)
      STEP_FIN_DY: deriv_v = mf - {{(AccW-CoordW){y_r[31]}}, y_r};
      STEP_FIN_DZ: deriv_v = {{FRAC_BITS{tmp_r[TmpW-1]}}, tmp_r} - mf;
      default:     deriv_v = mf;
    endcase
  end
  assign deriv_ovf = !((&deriv_v[AccW-1:DerivW-1]) || !(|deriv_v[AccW-1:DerivW-1]));
  assign deriv_sat = deriv_ovf ? {deriv_v[AccW-1], {(DerivW-1){!deriv_v[AccW-1]}}}
                               : deriv_v[DerivW-1:0];

  // coordinate finish: old + floor(d*dt / 2^16), clamp to 32 bits
  always_comb begin
    priority case (step_r)
      STEP_FIN_PY: coord_old = y_r;
      STEP_FIN_PZ: coord_old = z_r;
      default:     coord_old = x_r;
    endcase
  end
  assign coord_v   = $signed({{(AccW-CoordW){coord_old[31]}}, coord_old}) + (acc_r >>> DtW);
  assign coord_ovf = !((&coord_v[AccW-1:CoordW-1]) || !(|coord_v[AccW-1:CoordW-1]));
  assign coord_sat = coord_ovf ? {coord_v[AccW-1], {(CoordW-1){!coord_v[AccW-1]}}}
                               : coord_v[CoordW-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (in_tuser[0] == ACT_LOAD) ? S_EMIT : S_RUN;
      end
      S_RUN: begin
        if (step_r == STEP_LAST) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, gains and point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= '0;
      out_tvalid <= 1'b0;
      prod_en_r  <= 1'b0;
      ovf_r      <= 1'b0;
      sigma_r    <= SigmaRst[CoordW-1:0];
      rho_r      <= RhoRst[CoordW-1:0];
      beta_r     <= BetaRst[CoordW-1:0];
      x_r        <= PointRst[CoordW-1:0];
      y_r        <= PointRst[CoordW-1:0];
      z_r        <= PointRst[CoordW-1:0];
    end else begin
      state_r   <= state_nxt;
      prod_en_r <= mul_en;
      step_r    <= (state_r == S_RUN) ? step_r + 4'd1 : '0;

      if (cfg_valid && cfg_ready) begin
        priority case (cfg_index)
          REG_SIGMA: sigma_r <= cfg_data;
          REG_RHO:   rho_r   <= cfg_data;
          REG_BETA:  beta_r  <= cfg_data;
          default:   ;
        endcase
      end

      if (in_acc) begin
        ovf_r <= 1'b0;
        if (in_tuser[0] == ACT_LOAD) begin
          x_r <= in_tdata[47:16];
          y_r <= in_tdata[79:48];
          z_r <= in_tdata[111:80];
        end
      end else if (state_r == S_RUN) begin
        if (step_r == STEP_FIN_DX || step_r == STEP_FIN_DY || step_r == STEP_FIN_DZ) begin
          ovf_r <= ovf_r | deriv_ovf;
        end
        if (step_r == STEP_FIN_PX || step_r == STEP_FIN_PY || step_r == STEP_FIN_PZ) begin
          ovf_r <= ovf_r | coord_ovf;
        end
        if (step_r == STEP_FIN_PX) x_r <= coord_sat;
        if (step_r == STEP_FIN_PY) y_r <= coord_sat;
        if (step_r == STEP_FIN_PZ) z_r <= coord_sat;
      end

      if (emit_go) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

  // datapath payload, no reset
  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    prod_hi_r  <= mul_hi;
    prod_clr_r <= mul_clr;
    if (prod_en_r) acc_r <= acc_nxt;
    if (in_acc) dt_r <= in_tdata[15:0];
    if (state_r == S_RUN) begin
      if (step_r == STEP_FIN_DX) dx_r <= deriv_sat;
      if (step_r == STEP_FIN_DY) dy_r <= deriv_sat;
      if (step_r == STEP_FIN_XY) tmp_r <= mf[TmpW-1:0];
      if (step_r == STEP_FIN_DZ) dz_r <= deriv_sat;
    end
    if (emit_go) begin
      out_tdata <= {z_r, y_r, x_r};
      out_tuser <= ovf_r;
    end
  end

  // no request is taken while the sequencer runs
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !in_tready)
    else $error("input ready while sequencer running");

  // the run ends after the last step
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && step_r == STEP_LAST) |=> (state_r == S_EMIT))
    else $error("sequencer did not finish after last step");

  // a load request replaces the point and goes straight to the output stage
  a_load_point: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == ACT_LOAD) |=>
      (state_r == S_EMIT && x_r == $past(in_tdata[47:16]) && !ovf_r))
    else $error("load request not applied");

endmodule

// File: tb/sv/tb_lorenz_euler_integrator.sv
// tb_lorenz_euler_integrator: self-checking bench for the lorenz euler integrator,
// with a bit-exact step predictor, random idling, a long output stall and gain sweeps.
// depends on lei_pkg and lorenz_euler_integrator.
module tb_lorenz_euler_integrator;
  import lei_pkg::*;

  localparam int FracBits = 16;
  localparam int DtBits   = 16;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 24;

  // index past the register list, writes to it must be dropped
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic signed [95:0] DerivHi = (96'sd1 <<< 47) - 96'sd1;
  localparam logic signed [95:0] DerivLo = -(96'sd1 <<< 47);
  localparam logic signed [95:0] CoordHi = (96'sd1 <<< 31) - 96'sd1;
  localparam logic signed [95:0] CoordLo = -(96'sd1 <<< 31);

  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;

  // one input request as it travels on in_tuser and in_tdata
  typedef struct packed {
    logic        action;
    logic [15:0] dt;
    logic [31:0] lx;
    logic [31:0] ly;
    logic [31:0] lz;
  } lorenz_req_t;

  // one result as it travels on out_tdata and out_tuser
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        ovf;
  } point_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [0:0]   in_tuser = 1'b0;    // [0] action
  logic [111:0] in_tdata = '0;      // [15:0] dt, [47:16] x, [79:48] y, [111:80] z
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;          // [31:0] x, [63:32] y, [95:64] z
  logic [0:0]   out_tuser;          // [0] overflow
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  lorenz_euler_integrator #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // requests waiting for the driver, and results the block still owes us
  lorenz_req_t queued_requests[$];
  point_res_t  expected_points[$];

  int unsigned mismatch_count = 0;
  logic        req_taken = 1'b0;     // request accepted at the last rising edge
  logic        src_idle_on = 1'b1;   // sender may insert idle bursts
  logic        sink_idle_on = 1'b1;  // receiver may insert stall bursts
  logic        hold_request = 1'b0;  // ask the receiver for one long hold-off
  logic        hold_served = 1'b0;
  int unsigned hold_left = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;

  // predictor copy of the point and the gains
  logic signed [31:0] cur_x, cur_y, cur_z;
  logic signed [31:0] gain_sigma, gain_rho, gain_beta;

  // ---------------------------------------------------------------------------
  // step predictor
  // ---------------------------------------------------------------------------

  // exact fixed point product, floored back to the point format
  function automatic logic signed [95:0] fix_mul(input logic signed [95:0] a,
                                                 input logic signed [95:0] b);
    return (a * b) >>> FracBits;
  endfunction

  function automatic logic signed [95:0] saturate(input logic signed [95:0] v,
                                                  input logic signed [95:0] lo,
                                                  input logic signed [95:0] hi,
                                                  inout logic hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // applies one request to the predictor point and returns the result it causes
  function automatic point_res_t euler_advance(input lorenz_req_t r);
    logic signed [95:0] x, y, z, sg, rh, bt, dt, dx, dy, dz, nx, ny, nz;
    logic               ovf;
    point_res_t         res;
    ovf = 1'b0;
    if (r.action == ACT_LOAD) begin
      // load replaces the point, dt plays no part
      cur_x = r.lx;
      cur_y = r.ly;
      cur_z = r.lz;
    end else begin
      x  = cur_x;
      y  = cur_y;
      z  = cur_z;
      sg = gain_sigma;
      rh = gain_rho;
      bt = gain_beta;
      dt = $signed({80'd0, r.dt});
      // all three derivatives come from the old point
      dx = saturate(fix_mul(y - x, sg), DerivLo, DerivHi, ovf);
      dy = saturate(fix_mul(rh - z, x) - y, DerivLo, DerivHi, ovf);
      dz = saturate(fix_mul(x, y) - fix_mul(bt, z), DerivLo, DerivHi, ovf);
      nx = saturate(x + ((dx * dt) >>> DtBits), CoordLo, CoordHi, ovf);
      ny = saturate(y + ((dy * dt) >>> DtBits), CoordLo, CoordHi, ovf);
      nz = saturate(z + ((dz * dt) >>> DtBits), CoordLo, CoordHi, ovf);
      cur_x = nx[31:0];
      cur_y = ny[31:0];
      cur_z = nz[31:0];
    end
    res.x   = cur_x;
    res.y   = cur_y;
    res.z   = cur_z;
    res.ovf = ovf;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------

  // load fields carry random junk on a step, dt carries junk on a load
  function automatic lorenz_req_t make_step(input logic [15:0] dt);
    lorenz_req_t r;
    r.action = ACT_STEP;
    r.dt = dt;
    r.lx = $urandom;
    r.ly = $urandom;
    r.lz = $urandom;
    return r;
  endfunction

  function automatic lorenz_req_t make_load(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z);
    lorenz_req_t r;
    r.action = ACT_LOAD;
    r.dt = 16'($urandom);
    r.lx = x;
    r.ly = y;
    r.lz = z;
    return r;
  endfunction

  // mostly short steps along the trajectory, with loads to reseed it
  function automatic lorenz_req_t random_request();
    lorenz_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r = make_step(16'($urandom));
    if (pick < 25) begin
      if (pick < 15) begin
        // somewhere near the attractor
        r = make_load(32'($urandom_range(0, 6553600)) - 32'd3276800,
                      32'($urandom_range(0, 6553600)) - 32'd3276800,
                      32'($urandom_range(0, 3276800)));
      end else if (pick < 20) begin
        r = make_load($urandom_range(0, 1) ? Q_MAX : Q_MIN,
                      $urandom_range(0, 1) ? Q_MAX : Q_MIN,
                      $urandom_range(0, 1) ? Q_MAX : Q_MIN);
      end else begin
        r = make_load($urandom, $urandom, $urandom);
      end
    end else if (pick < 85) begin
      r.dt = 16'($urandom_range(0, 1300));
    end else if (pick < 88) begin
      r.dt = pick[0] ? 16'hFFFF : 16'h0000;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: pops queued requests, holds each until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    lorenz_req_t next_req;
    if (!rst_n || (in_tvalid && !req_taken)) begin
      // keep offering the same request
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      in_tvalid <= 1'b0;
    end else if (queued_requests.size() != 0 && src_idle_on && $urandom_range(0, 5) == 0) begin
      src_gap <= $urandom_range(0, 6);
      in_tvalid <= 1'b0;
    end else if (queued_requests.size() != 0) begin
      next_req = queued_requests.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= next_req.action;
      in_tdata <= {next_req.lz, next_req.ly, next_req.lx, next_req.dt};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stall bursts plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request && !hold_served) begin
      hold_served <= 1'b1;
      hold_left <= HoldCycles;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_tready <= 1'b0;
    end else if (rst_n && sink_idle_on && $urandom_range(0, 4) == 0) begin
      sink_gap <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: tracks accepted requests and gain writes, checks every result
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    point_res_t want;
    if (!rst_n) begin
      gain_sigma = 32'sd655360;
      gain_rho   = 32'sd1835008;
      gain_beta  = 32'sd174763;
      cur_x = 32'sd6554;
      cur_y = 32'sd6554;
      cur_z = 32'sd6554;
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIGMA: gain_sigma = cfg_data;
          REG_RHO:   gain_rho   = cfg_data;
          REG_BETA:  gain_beta  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_points.push_back(euler_advance({in_tuser[0], in_tdata[15:0],
                                                 in_tdata[47:16], in_tdata[79:48],
                                                 in_tdata[111:80]}));
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("result with no request outstanding: x %0d y %0d z %0d",
                 $signed(out_tdata[31:0]), $signed(out_tdata[63:32]),
                 $signed(out_tdata[95:64]));
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("out_x", want.x, out_tdata[31:0]);
          check_field("out_y", want.y, out_tdata[63:32]);
          check_field("out_z", want.z, out_tdata[95:64]);
          check_field("overflow", 32'(want.ovf), 32'(out_tuser[0]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------

  // waits until every queued request went in and its result came back
  task automatic settle();
    while (queued_requests.size() != 0 || in_tvalid || expected_points.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_gain(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes all three gains plus one dropped write past the register list
  task automatic apply_gains(input logic [31:0] sigma, input logic [31:0] rho,
                             input logic [31:0] beta);
    write_gain(REG_SIGMA, sigma);
    write_gain(REG_SPARE, $urandom);
    write_gain(REG_RHO, rho);
    write_gain(REG_BETA, beta);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    repeat (n) queued_requests.push_back(random_request());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the default gains, starting from the reset point
    queued_requests.push_back(make_step(16'h0000));          // zero step
    queued_requests.push_back(make_step(16'hFFFF));
    queued_requests.push_back(make_step(16'h0001));
    queued_requests.push_back(make_load(32'd0, 32'd0, 32'd0));
    queued_requests.push_back(make_step(16'hFFFF));          // origin is a fixed point
    queued_requests.push_back(make_load(Q_MAX, Q_MAX, Q_MAX));
    queued_requests.push_back(make_step(16'hFFFF));          // coordinates clamp
    queued_requests.push_back(make_load(Q_MIN, Q_MIN, Q_MIN));
    queued_requests.push_back(make_step(16'hFFFF));
    queued_requests.push_back(make_load(Q_MIN, Q_MAX, 32'd0));
    queued_requests.push_back(make_step(16'hFFFF));
    queued_requests.push_back(make_step(16'h0000));
    queued_requests.push_back(make_load(Q_ONE, Q_ONE, Q_ONE));
    queued_requests.push_back(make_step(16'd655));
    queued_requests.push_back(make_step(16'h8000));
    queued_requests.push_back(make_load(Q_MAX, Q_MIN, Q_MAX));
    queued_requests.push_back(make_step(16'h5555));
    queued_requests.push_back(make_step(16'hAAAA));
    queued_requests.push_back(make_load(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F));
    queued_requests.push_back(make_step(16'h00FF));
    queued_requests.push_back(make_load(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000));
    queued_requests.push_back(make_step(16'hFF00));
    queue_random(200);
    settle();

    // extreme gains, derivatives clamp at 48 bits
    apply_gains(Q_MAX, Q_MIN, Q_MAX);
    queued_requests.push_back(make_load(Q_MIN, Q_MAX, 32'd0));
    queued_requests.push_back(make_step(16'hFFFF));
    queued_requests.push_back(make_load(Q_MAX, Q_MIN, Q_MAX));
    queued_requests.push_back(make_step(16'hFFFF));
    queue_random(150);
    settle();

    // opposite extremes, a stretch with no idling on either side
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    apply_gains(Q_MIN, Q_MAX, Q_MIN);
    queue_random(150);
    settle();

    // full range random gains; the receiver holds off while requests keep coming
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    apply_gains($urandom, $urandom, $urandom);
    queue_random(150);
    hold_request = 1'b1;
    settle();

    // lorenz-like gains
    apply_gains(32'($urandom_range(5 << 16, 15 << 16)), 32'($urandom_range(10 << 16, 40 << 16)),
                32'($urandom_range(1 << 16, 4 << 16)));
    queue_random(200);
    settle();

    // zero gains, last part without any idling
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    apply_gains(32'd0, 32'd0, 32'd0);
    queue_random(150);
    settle();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
